// ===== design/s256_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package s256_pkg;

  localparam int unsigned QueueDepth = 4;

  typedef logic [31:0] word_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_valid;
    logic       last;
  } in_item_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } out_item_t;

  // classified operation passed from front to back
  typedef struct packed {
    logic [7:0] data_byte;
    logic       push_byte;
    logic       finish;
  } op_t;

  localparam logic [255:0] InitHash = {
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [7:0] PadByte = 8'h80;

  function automatic word_t round_k(input logic [5:0] i);
    word_t k;
    case (i)
      6'd0: k = 32'h428a2f98;  6'd1: k = 32'h71374491;
      6'd2: k = 32'hb5c0fbcf;  6'd3: k = 32'he9b5dba5;
      6'd4: k = 32'h3956c25b;  6'd5: k = 32'h59f111f1;
      6'd6: k = 32'h923f82a4;  6'd7: k = 32'hab1c5ed5;
      6'd8: k = 32'hd807aa98;  6'd9: k = 32'h12835b01;
      6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe;
      6'd14: k = 32'h9bdc06a7; 6'd15: k = 32'hc19bf174;
      6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc;
      6'd20: k = 32'h2de92c6f; 6'd21: k = 32'h4a7484aa;
      6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d;
      6'd26: k = 32'hb00327c8; 6'd27: k = 32'hbf597fc7;
      6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967;
      6'd32: k = 32'h27b70a85; 6'd33: k = 32'h2e1b2138;
      6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb;
      6'd38: k = 32'h81c2c92e; 6'd39: k = 32'h92722c85;
      6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3;
      6'd44: k = 32'hd192e819; 6'd45: k = 32'hd6990624;
      6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08;
      6'd50: k = 32'h2748774c; 6'd51: k = 32'h34b0bcb5;
      6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3;
      6'd56: k = 32'h748f82ee; 6'd57: k = 32'h78a5636f;
      6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb;
      6'd62: k = 32'hbef9a3f7; default: k = 32'hc67178f2;
    endcase
    return k;
  endfunction

endpackage
`default_nettype wire

// ===== design/s256_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
interface s256_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

// ===== design/s256_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
module s256_front #(
  parameter int unsigned Depth = s256_pkg::QueueDepth
) (
  input  wire logic           clk,
  input  wire logic           rst,
  s256_if.sink                in_ch,
  output s256_pkg::op_t       op,
  output logic                op_valid,
  input  wire logic           op_ready
);

  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;

  s256_pkg::op_t  q [Depth];
  logic [AW-1:0]  wr_ptr;
  logic [AW-1:0]  rd_ptr;
  logic [AW:0]    count;
  s256_pkg::op_t  cls;
  logic           keep;
  logic           push;
  logic           pop;

  // an invalid byte without last carries no work and is dropped here
  always_comb begin
    cls.data_byte = in_ch.payload.data_byte;
    cls.push_byte = in_ch.payload.byte_valid;
    cls.finish    = in_ch.payload.last;
    keep          = in_ch.payload.byte_valid | in_ch.payload.last;
  end

  assign in_ch.ready = (count != (AW+1)'(Depth));
  assign push        = in_ch.valid & in_ch.ready & keep;
  assign pop         = op_valid & op_ready;
  assign op_valid    = (count != '0);
  assign op          = q[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        q[wr_ptr] <= cls;
        wr_ptr    <= (wr_ptr == AW'(Depth - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(Depth - 1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + (AW+1)'(push) - (AW+1)'(pop);
    end
  end

endmodule
`default_nettype wire

// ===== design/s256_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
module s256_back (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           double_mode,
  input  wire s256_pkg::op_t  op,
  input  wire logic           op_valid,
  output logic                op_ready,
  s256_if.source              out_ch
);

  typedef enum logic [2:0] {
    ST_IDLE, ST_PAD, ST_ROUND, ST_ADD, ST_EMIT
  } state_t;

  // what follows the current compression
  typedef enum logic [1:0] {
    AFT_NONE, AFT_PAD, AFT_FINAL, AFT_SECOND
  } after_t;

  state_t                   state;
  after_t                   after;
  logic [511:0]             blk_q;
  logic [5:0]               fill;
  logic [60:0]              msg_bytes;
  logic [255:0]             chain;
  logic [255:0]             work;
  logic [511:0]             sched;
  logic [5:0]               rnd;
  logic                     pad_done;
  logic                     dbl_run;
  logic [2:0]               widx;
  logic [255:0]             result;

  logic [31:0] a, b, c, d, e, f, g, h, w0, t1, t2, s0, s1, wn, x, y;
  logic [63:0]  bits;
  logic [7:0]   pad_byte;
  logic [255:0] chain_sum;
  logic [255:0] sum2;

  assign bits     = {msg_bytes, 3'b000};
  // first padding byte is 0x80, the rest of the fill is zero
  assign pad_byte = pad_done ? 8'h00 : s256_pkg::PadByte;

  always_comb begin
    a = work[255:224]; b = work[223:192]; c = work[191:160]; d = work[159:128];
    e = work[127:96];  f = work[95:64];   g = work[63:32];   h = work[31:0];
    w0 = sched[511:480];
    t1 = h + ({e[5:0], e[31:6]} ^ {e[10:0], e[31:11]} ^ {e[24:0], e[31:25]})
         + ((e & f) ^ (~e & g)) + s256_pkg::round_k(rnd) + w0;
    t2 = ({a[1:0], a[31:2]} ^ {a[12:0], a[31:13]} ^ {a[21:0], a[31:22]})
         + ((a & b) ^ (a & c) ^ (b & c));
    x  = sched[479:448];
    y  = sched[63:32];
    s0 = {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ (x >> 3);
    s1 = {y[16:0], y[31:17]} ^ {y[18:0], y[31:19]} ^ (y >> 10);
    wn = s1 + sched[223:192] + s0 + w0;
  end

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      chain_sum[255 - 32*i -: 32] = chain[255 - 32*i -: 32] + work[255 - 32*i -: 32];
      sum2[255 - 32*i -: 32] = s256_pkg::InitHash[255 - 32*i -: 32]
                               + work[255 - 32*i -: 32];
    end
  end

  assign op_ready       = (state == ST_IDLE);
  assign out_ch.valid   = (state == ST_EMIT);
  assign out_ch.payload.digest_word = result[255:224];
  assign out_ch.payload.word_index  = widx;
  assign out_ch.payload.last_word   = (widx == 3'd7);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      after     <= AFT_NONE;
      fill      <= '0;
      msg_bytes <= '0;
      chain     <= s256_pkg::InitHash;
      rnd       <= '0;
      widx      <= '0;
      pad_done  <= 1'b0;
      dbl_run   <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (op_valid) begin
            dbl_run  <= double_mode;
            pad_done <= 1'b0;
            if (op.push_byte) begin
              blk_q     <= {blk_q[503:0], op.data_byte};
              fill      <= fill + 6'd1;
              msg_bytes <= msg_bytes + 61'd1;
            end
            if (op.push_byte && fill == 6'd63) begin
              // full block: compress, then pad if this was the last byte
              sched <= {blk_q[503:0], op.data_byte};
              work  <= chain;
              rnd   <= '0;
              after <= op.finish ? AFT_PAD : AFT_NONE;
              state <= ST_ROUND;
            end else if (op.finish) begin
              state <= ST_PAD;
            end
          end
        end
        ST_PAD: begin
          if (pad_done && fill == 6'd56) begin
            // bit length fills the last eight bytes
            sched <= {blk_q[447:0], bits};
            work  <= chain;
            rnd   <= '0;
            after <= AFT_FINAL;
            state <= ST_ROUND;
          end else begin
            blk_q    <= {blk_q[503:0], pad_byte};
            fill     <= fill + 6'd1;
            pad_done <= 1'b1;
            if (fill == 6'd63) begin
              sched <= {blk_q[503:0], pad_byte};
              work  <= chain;
              rnd   <= '0;
              after <= AFT_PAD;
              state <= ST_ROUND;
            end
          end
        end
        ST_ROUND: begin
          work  <= {t1 + t2, a, b, c, d + t1, e, f, g};
          sched <= {sched[479:0], wn};
          rnd   <= rnd + 6'd1;
          if (rnd == 6'd63) state <= ST_ADD;
        end
        ST_ADD: begin
          rnd <= '0;
          unique case (after)
            AFT_NONE: begin
              chain <= chain_sum;
              state <= ST_IDLE;
            end
            AFT_PAD: begin
              chain <= chain_sum;
              state <= ST_PAD;
            end
            AFT_FINAL: begin
              chain <= chain_sum;
              if (dbl_run) begin
                sched <= {chain_sum, 32'h80000000, 192'd0, 32'd256};
                work  <= s256_pkg::InitHash;
                after <= AFT_SECOND;
                state <= ST_ROUND;
              end else begin
                result <= chain_sum;
                widx   <= '0;
                state  <= ST_EMIT;
              end
            end
            default: begin
              result <= sum2;
              widx   <= '0;
              state  <= ST_EMIT;
            end
          endcase
        end
        ST_EMIT: begin
          if (out_ch.ready) begin
            result <= {result[223:0], 32'd0};
            widx   <= widx + 3'd1;
            if (widx == 3'd7) begin
              state     <= ST_IDLE;
              chain     <= s256_pkg::InitHash;
              fill      <= '0;
              msg_bytes <= '0;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== design/sha256_stream_hasher_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// bytes are taken one a cycle while the queue has room and reach the back end
// only while it is idle; a 64-byte block runs 64 rounds, one a cycle, then the
// chaining add; on last the pad byte and zero fill go in one byte a cycle, then
// the bit length fills the last eight bytes; double mode hashes the digest once
// more; words leave one a cycle while out_ch is ready
// synchronous reset restores the initial hash, clears counts and double_mode
module sha256_stream_hasher_unit #(
  parameter int unsigned QueueDepth = s256_pkg::QueueDepth
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic cfg_we,
  input  wire logic cfg_wdata,
  s256_if.sink      in_ch,
  s256_if.source    out_ch
);

  logic          double_mode;
  s256_pkg::op_t op;
  logic          op_valid;
  logic          op_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      double_mode <= 1'b0;
    end else if (cfg_we) begin
      double_mode <= cfg_wdata;
    end
  end

  s256_front #(.Depth(QueueDepth)) u_front (
    .clk, .rst, .in_ch, .op, .op_valid, .op_ready
  );

  s256_back u_back (
    .clk, .rst, .double_mode, .op, .op_valid, .op_ready, .out_ch
  );

  a_word_order: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && out_ch.ready && out_ch.payload.word_index != 3'd7
    |=> out_ch.valid && out_ch.payload.word_index == $past(out_ch.payload.word_index) + 3'd1)
    else $error("digest words out of order");

  a_last_flag: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid |-> out_ch.payload.last_word == (out_ch.payload.word_index == 3'd7))
    else $error("last_word mismatch");

  a_no_pop_busy: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid |-> !op_ready)
    else $error("back end took work while emitting");

endmodule
`default_nettype wire
